### rtl/pfsr_pkg.sv
package pfsr_pkg;

  // default geometry of the ring
  localparam int PFSR_SLOT_COUNT      = 8;
  localparam int PFSR_FRAMES_PER_SLOT = 64;
  localparam int PFSR_FRAME_BYTES     = 4;

  // stream widths
  localparam int IN_DATA_W  = 104;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 152;
  localparam int OUT_USER_W = 3;

  typedef enum logic [1:0] {
    OP_APPEND  = 2'd0,
    OP_FINISH  = 2'd1,
    OP_READ    = 2'd2,
    OP_CONSUME = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_EMPTY    = 3'd2,
    STAT_OFFSET   = 3'd3,
    STAT_FINAL    = 3'd4,
    STAT_OVERFLOW = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FETCH,
    ST_DONE
  } ctrl_state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic execute;
    logic fetch;
    logic publish;
  } pfsr_cmd_t;

endpackage

### rtl/pcm_frame_slot_ring.sv
// channel  | ports               | item contents
// ---------+---------------------+----------------------------------------------
// in       | in_tvalid/tready    | tuser: op; tdata: offset, frame, frame index
// out      | out_tvalid/tready   | tuser: status; tdata: read frame, oldest slot
//          |                     | header, occupancy, partial count, finalized
//
// each item goes through four steps: capture, execute, memory fetch, publish;
// the fetch step serves the registered reads of the frame store and headers
// an item is accepted while a previous result still sits in the output register
// a stalled output holds the controller in its publish state
// reset is synchronous, active low, clears pointers, counters and flags only
// the frame store and slot headers need no clearing pass: never read unwritten
module pcm_frame_slot_ring
  import pfsr_pkg::*;
#(
  parameter int SLOT_COUNT      = PFSR_SLOT_COUNT,
  parameter int FRAMES_PER_SLOT = PFSR_FRAMES_PER_SLOT,
  parameter int FRAME_BYTES     = PFSR_FRAME_BYTES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // offset[63:0], frame_data[95:64], frame_index[101:96], zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // op[1:0]
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // read_data[31:0], slot_start_offset[95:32], slot_sequence[127:96],
  // slot_frame_count[134:128], slot_final_partial[135], occupancy[139:136],
  // partial_frames[145:140], is_finalized[146], zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  // status[2:0]
  output logic [OUT_USER_W-1:0] out_tuser
);

  pfsr_cmd_t cmd;

  // sequencer: handshakes and the per-item step order
  pfsr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // ring state, frame store, slot headers and the result register
  pfsr_dp #(
    .SLOT_COUNT      (SLOT_COUNT),
    .FRAMES_PER_SLOT (FRAMES_PER_SLOT),
    .FRAME_BYTES     (FRAME_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

### rtl/pfsr_ctrl.sv
module pfsr_ctrl
  import pfsr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  output pfsr_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.execute = 1'b1;
        state_nxt   = ST_FETCH;
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // output register free or being emptied this cycle
        if (!out_valid_r || out_tready) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

### rtl/pfsr_dp.sv
module pfsr_dp
  import pfsr_pkg::*;
#(
  parameter int SLOT_COUNT      = PFSR_SLOT_COUNT,
  parameter int FRAMES_PER_SLOT = PFSR_FRAMES_PER_SLOT,
  parameter int FRAME_BYTES     = PFSR_FRAME_BYTES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pfsr_cmd_t             cmd,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [OUT_USER_W-1:0] out_tuser
);

  localparam int SLOT_W    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int PTR_W     = SLOT_W + 1;
  localparam int FILL_W    = $clog2(FRAMES_PER_SLOT + 1);
  localparam int PCM_DEPTH = SLOT_COUNT * FRAMES_PER_SLOT;
  localparam int ADDR_W    = $clog2(PCM_DEPTH);
  localparam int DATA_W    = (FRAME_BYTES >= 4) ? 32 : 8 * FRAME_BYTES;

  localparam logic [PTR_W-1:0]  PTR_MOD   = PTR_W'(2 * SLOT_COUNT);
  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(2 * SLOT_COUNT - 1);
  localparam logic [PTR_W-1:0]  SLOTS_P   = PTR_W'(SLOT_COUNT);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(FRAMES_PER_SLOT);
  localparam logic [ADDR_W-1:0] FPS_A     = ADDR_W'(FRAMES_PER_SLOT);

  // captured item
  op_t         op_r;
  logic [63:0] off_r;
  logic [31:0] data_r;
  logic [5:0]  idx_r;

  // ring control state
  logic [PTR_W-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [63:0]       next_off_r, next_off_nxt;
  logic [31:0]       seq_r, seq_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              done_r, done_nxt;
  status_t           status_r, status_nxt;
  logic              rd_hit_r, rd_hit_nxt;

  // storage
  logic [DATA_W-1:0] pcm_mem [PCM_DEPTH];
  logic [63:0]       hoff_mem [SLOT_COUNT];
  logic [31:0]       hseq_mem [SLOT_COUNT];
  logic [FILL_W-1:0] hcnt_mem [SLOT_COUNT];
  logic              hfin_mem [SLOT_COUNT];

  logic [DATA_W-1:0] pcm_rd_r;
  logic [63:0]       hoff_rd_r;
  logic [31:0]       hseq_rd_r;
  logic [FILL_W-1:0] hcnt_rd_r;
  logic              hfin_rd_r;

  // output register
  status_t     o_status_r;
  logic [31:0] o_rdata_r;
  logic [63:0] o_off_r;
  logic [31:0] o_seq_r;
  logic [6:0]  o_cnt_r;
  logic        o_fin_r;
  logic [3:0]  o_occ_r;
  logic [5:0]  o_part_r;
  logic        o_done_r;

  logic [PTR_W-1:0]  waiting;
  logic              ring_full;
  logic [SLOT_W-1:0] wslot, rslot;
  logic [FILL_W-1:0] fill_inc, commit_cnt;
  logic              pcm_we, start_we, commit_we, commit_fin;
  logic [ADDR_W-1:0] pcm_waddr, pcm_raddr;
  logic              rd_ok;

  // pointers count modulo twice the slot count
  assign waiting   = wp_r - rp_r + ((wp_r < rp_r) ? PTR_MOD : '0);
  assign ring_full = (waiting >= SLOTS_P);
  assign wslot     = (wp_r >= SLOTS_P) ? SLOT_W'(wp_r - SLOTS_P) : SLOT_W'(wp_r);
  assign rslot     = (rp_r >= SLOTS_P) ? SLOT_W'(rp_r - SLOTS_P) : SLOT_W'(rp_r);
  assign fill_inc  = fill_r + 1'b1;
  assign pcm_waddr = ADDR_W'(ADDR_W'(wslot) * FPS_A) + ADDR_W'(fill_r);
  assign pcm_raddr = ADDR_W'(ADDR_W'(rslot) * FPS_A) + ADDR_W'(idx_r);

  always_comb begin
    wp_nxt       = wp_r;
    rp_nxt       = rp_r;
    next_off_nxt = next_off_r;
    seq_nxt      = seq_r;
    fill_nxt     = fill_r;
    done_nxt     = done_r;
    status_nxt   = STAT_OK;
    rd_hit_nxt   = 1'b0;
    pcm_we       = 1'b0;
    start_we     = 1'b0;
    commit_we    = 1'b0;
    commit_cnt   = fill_r;
    commit_fin   = 1'b0;
    case (op_r)
      OP_APPEND: begin
        if (done_r) begin
          status_nxt = STAT_FINAL;
        end else if (off_r != next_off_r) begin
          status_nxt = STAT_OFFSET;
        end else if (next_off_r == '1) begin
          status_nxt = STAT_OVERFLOW;
        end else if (ring_full) begin
          status_nxt = STAT_FULL;
        end else begin
          pcm_we       = 1'b1;
          start_we     = (fill_r == '0);
          next_off_nxt = next_off_r + 64'd1;
          if (fill_inc == FILL_FULL) begin
            commit_we  = 1'b1;
            commit_cnt = FILL_FULL;
            wp_nxt     = (wp_r == PTR_LAST) ? '0 : wp_r + 1'b1;
            seq_nxt    = seq_r + 32'd1;
            fill_nxt   = '0;
          end else begin
            fill_nxt = fill_inc;
          end
        end
      end
      OP_FINISH: begin
        if (done_r) begin
          status_nxt = STAT_FINAL;
        end else if (off_r != next_off_r) begin
          status_nxt = STAT_OFFSET;
        end else if (fill_r == '0) begin
          done_nxt = 1'b1;
        end else if (ring_full) begin
          status_nxt = STAT_FULL;
        end else begin
          // close the partial slot as the final one
          commit_we  = 1'b1;
          commit_fin = 1'b1;
          wp_nxt     = (wp_r == PTR_LAST) ? '0 : wp_r + 1'b1;
          seq_nxt    = seq_r + 32'd1;
          fill_nxt   = '0;
          done_nxt   = 1'b1;
        end
      end
      OP_READ: begin
        if (waiting == '0) status_nxt = STAT_EMPTY;
        else               rd_hit_nxt = 1'b1;
      end
      OP_CONSUME: begin
        if (waiting == '0) status_nxt = STAT_EMPTY;
        else               rp_nxt = (rp_r == PTR_LAST) ? '0 : rp_r + 1'b1;
      end
      default: status_nxt = STAT_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= op_t'(in_tuser[1:0]);
      off_r  <= in_tdata[63:0];
      data_r <= in_tdata[95:64];
      idx_r  <= in_tdata[101:96];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      rp_r       <= '0;
      next_off_r <= '0;
      seq_r      <= '0;
      fill_r     <= '0;
      done_r     <= 1'b0;
      status_r   <= STAT_OK;
      rd_hit_r   <= 1'b0;
    end else if (cmd.execute) begin
      wp_r       <= wp_nxt;
      rp_r       <= rp_nxt;
      next_off_r <= next_off_nxt;
      seq_r      <= seq_nxt;
      fill_r     <= fill_nxt;
      done_r     <= done_nxt;
      status_r   <= status_nxt;
      rd_hit_r   <= rd_hit_nxt;
    end
  end

  // frame store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.execute && pcm_we) pcm_mem[pcm_waddr] <= DATA_W'(data_r);
    if (cmd.fetch)             pcm_rd_r <= pcm_mem[pcm_raddr];
  end

  // slot headers, written at the fill slot, read at the oldest slot
  always_ff @(posedge clk) begin
    if (cmd.execute && start_we) begin
      hoff_mem[wslot] <= next_off_r;
      hseq_mem[wslot] <= seq_r;
    end
    if (cmd.execute && commit_we)            hcnt_mem[wslot] <= commit_cnt;
    if (cmd.execute && (start_we || commit_we)) hfin_mem[wslot] <= commit_we && commit_fin;
    if (cmd.fetch) begin
      hoff_rd_r <= hoff_mem[rslot];
      hseq_rd_r <= hseq_mem[rslot];
      hcnt_rd_r <= hcnt_mem[rslot];
      hfin_rd_r <= hfin_mem[rslot];
    end
  end

  assign rd_ok = rd_hit_r && (32'(idx_r) < 32'(hcnt_rd_r))
                 && (32'(idx_r) < 32'(FRAMES_PER_SLOT));

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      o_status_r <= status_r;
      o_rdata_r  <= rd_ok ? 32'(pcm_rd_r) : 32'd0;
      o_off_r    <= (waiting != '0) ? hoff_rd_r : 64'd0;
      o_seq_r    <= (waiting != '0) ? hseq_rd_r : 32'd0;
      o_cnt_r    <= (waiting != '0) ? 7'(hcnt_rd_r) : 7'd0;
      o_fin_r    <= (waiting != '0) && hfin_rd_r;
      o_occ_r    <= 4'(waiting);
      o_part_r   <= 6'(fill_r);
      o_done_r   <= done_r;
    end
  end

  assign out_tdata = {5'd0, o_done_r, o_part_r, o_occ_r, o_fin_r, o_cnt_r,
                      o_seq_r, o_off_r, o_rdata_r};
  assign out_tuser = o_status_r;

endmodule

### rtl/pfsr_chk.sv
module pfsr_chk
  import pfsr_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_DATA_W-1:0]  in_tdata,
  input logic [IN_USER_W-1:0]  in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [OUT_USER_W-1:0] out_tuser
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // one item at a time: ready drops right after an accept
  a_in_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while another is in work");

  // an empty ring reports no waiting slot and a clear header
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == STAT_EMPTY) |->
      (out_tdata[139:136] == 4'd0) && (out_tdata[135:32] == '0))
    else $error("empty status with a slot waiting");

  // finalized status only once finish has gone through
  a_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == STAT_FINAL) |-> out_tdata[146])
    else $error("finalized status without finalized flag");

endmodule

bind pcm_frame_slot_ring pfsr_chk u_pfsr_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### tb/sv/tb_pcm_frame_slot_ring.sv
`timescale 1ns / 1ps

module tb_pcm_frame_slot_ring;
  import pfsr_pkg::*;

  localparam int SLOTS       = PFSR_SLOT_COUNT;
  localparam int FPS         = PFSR_FRAMES_PER_SLOT;
  localparam int PTR_SPAN    = 2 * SLOTS;
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_OPS  = 850;
  localparam logic [31:0] FRAME_MASK = (PFSR_FRAME_BYTES >= 4) ? 32'hFFFF_FFFF :
                                       32'((64'd1 << (8 * PFSR_FRAME_BYTES)) - 64'd1);

  // one result item, unpacked from out_tuser / out_tdata
  typedef struct packed {
    status_t     status;
    logic [31:0] read_data;
    logic [63:0] start_offset;
    logic [31:0] seq_no;
    logic [6:0]  frame_cnt;
    logic        final_partial;
    logic [3:0]  occupancy;
    logic [5:0]  partial_frames;
    logic        finalized;
  } ring_report_t;

  // one line of the directed plan
  typedef struct packed {
    op_t         op;
    int          reps;
    logic        rel_offset;   // offset is a delta on the running offset
    logic [63:0] ofs;
    logic [31:0] data;         // used only when reps is 1
    logic [5:0]  idx;
    logic        pinned;       // status and read frame typed in below
    status_t     pin_status;
    logic [31:0] pin_rdata;
  } plan_row_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [IN_USER_W-1:0]  in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  // idle percentages of the two sides, changed per phase
  int tx_idle_pct = 33;
  int rx_idle_pct = 74;

  int mismatch_count = 0;
  int quiet_cycles   = 0;

  ring_report_t awaited_reports[$];

  // predicted ring contents and control state
  logic [31:0] frame_mem  [SLOTS*FPS];
  logic [63:0] hdr_offset [SLOTS];
  logic [31:0] hdr_seq    [SLOTS];
  logic [6:0]  hdr_count  [SLOTS];
  logic        hdr_final  [SLOTS];
  int          wr_ptr      = 0;
  int          rd_ptr      = 0;
  logic [63:0] next_offset = '0;
  logic [31:0] seq_ctr     = '0;
  int          fill        = 0;
  logic        finished    = 1'b0;

  // directed plan: errors after reset, data extremes, a full ring,
  // wrong offsets on both sides of the running one, and a drain to empty
  plan_row_t directed_plan [0:22] = '{
    '{OP_READ,    1,   1'b0, 64'd0, 32'd0, 6'd0,  1'b1, STAT_EMPTY,  32'd0},
    '{OP_CONSUME, 1,   1'b0, 64'd0, 32'd0, 6'd0,  1'b1, STAT_EMPTY,  32'd0},
    '{OP_APPEND,  1,   1'b0, 64'd1, 32'd0, 6'd0,  1'b1, STAT_OFFSET, 32'd0},
    '{OP_APPEND,  1,   1'b0, '1,    '1,    '1,    1'b1, STAT_OFFSET, 32'd0},
    '{OP_FINISH,  1,   1'b0, 64'd5, 32'd0, 6'd0,  1'b1, STAT_OFFSET, 32'd0},
    '{OP_APPEND,  1,   1'b1, 64'd0, 32'd0, 6'd0,  1'b1, STAT_OK,     32'd0},
    '{OP_APPEND,  1,   1'b1, 64'd0, '1,    6'd0,  1'b1, STAT_OK,     32'd0},
    '{OP_APPEND,  62,  1'b1, 64'd0, 32'd0, 6'd0,  1'b0, STAT_OK,     32'd0},
    '{OP_READ,    1,   1'b0, 64'd0, 32'd0, 6'd0,  1'b1, STAT_OK,     32'd0},
    '{OP_READ,    1,   1'b0, 64'd0, 32'd0, 6'd1,  1'b1, STAT_OK,     '1},
    '{OP_READ,    1,   1'b0, 64'd0, 32'd0, 6'd63, 1'b0, STAT_OK,     32'd0},
    '{OP_APPEND,  448, 1'b1, 64'd0, 32'd0, 6'd0,  1'b0, STAT_OK,     32'd0},
    '{OP_APPEND,  1,   1'b1, 64'd0, 32'd0, 6'd0,  1'b1, STAT_FULL,   32'd0},
    '{OP_READ,    1,   1'b0, 64'd0, 32'd0, 6'd32, 1'b0, STAT_OK,     32'd0},
    '{OP_CONSUME, 1,   1'b0, 64'd0, 32'd0, 6'd0,  1'b1, STAT_OK,     32'd0},
    '{OP_CONSUME, 1,   1'b0, 64'd0, 32'd0, 6'd0,  1'b1, STAT_OK,     32'd0},
    '{OP_APPEND,  5,   1'b1, 64'd0, 32'd0, 6'd0,  1'b0, STAT_OK,     32'd0},
    '{OP_FINISH,  1,   1'b1, 64'd1, 32'd0, 6'd0,  1'b1, STAT_OFFSET, 32'd0},
    '{OP_APPEND,  1,   1'b1, '1,    32'd0, 6'd0,  1'b1, STAT_OFFSET, 32'd0},
    '{OP_FINISH,  1,   1'b1, '1,    32'd0, 6'd0,  1'b1, STAT_OFFSET, 32'd0},
    '{OP_CONSUME, 6,   1'b0, 64'd0, 32'd0, 6'd0,  1'b0, STAT_OK,     32'd0},
    '{OP_CONSUME, 1,   1'b0, 64'd0, 32'd0, 6'd0,  1'b1, STAT_EMPTY,  32'd0},
    '{OP_READ,    1,   1'b0, 64'd0, 32'd0, 6'd63, 1'b1, STAT_EMPTY,  32'd0}
  };

  pcm_frame_slot_ring u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // committed slots waiting; pointers run modulo twice the ring size
  function automatic int ring_occupancy();
    return (wr_ptr + PTR_SPAN - rd_ptr) % PTR_SPAN;
  endfunction

  // stamp the slot under the write pointer and move on
  function automatic void close_slot(int count, logic is_last);
    int s;
    s = wr_ptr % SLOTS;
    hdr_count[s] = 7'(count);
    hdr_final[s] = is_last;
    wr_ptr       = (wr_ptr + 1) % PTR_SPAN;
    seq_ctr      = seq_ctr + 32'd1;
    fill         = 0;
  endfunction

  // work out the result of one accepted item and advance the ring
  // note: offset overflow needs a running offset of all ones, which is out of
  // reach from reset; likewise a partial slot can never sit beside a full ring
  function automatic ring_report_t apply_ring_op(op_t op, logic [63:0] ofs,
                                                 logic [31:0] data, logic [5:0] idx);
    ring_report_t r;
    int s;
    r = '0;
    r.status = STAT_OK;
    case (op)
      OP_APPEND: begin
        if (finished) r.status = STAT_FINAL;
        else if (ofs != next_offset) r.status = STAT_OFFSET;
        else if (next_offset == '1) r.status = STAT_OVERFLOW;
        else if (ring_occupancy() >= SLOTS) r.status = STAT_FULL;
        else begin
          s = wr_ptr % SLOTS;
          if (fill == 0) begin
            hdr_offset[s] = next_offset;
            hdr_seq[s]    = seq_ctr;
            hdr_final[s]  = 1'b0;
          end
          frame_mem[s*FPS + fill] = data & FRAME_MASK;
          fill++;
          next_offset = next_offset + 64'd1;
          if (fill >= FPS) close_slot(FPS, 1'b0);
        end
      end
      OP_FINISH: begin
        if (finished) r.status = STAT_FINAL;
        else if (ofs != next_offset) r.status = STAT_OFFSET;
        else if (fill == 0) finished = 1'b1;
        else if (ring_occupancy() >= SLOTS) r.status = STAT_FULL;
        else begin
          close_slot(fill, 1'b1);
          finished = 1'b1;
        end
      end
      OP_READ: begin
        if (ring_occupancy() == 0) r.status = STAT_EMPTY;
        else begin
          s = rd_ptr % SLOTS;
          // frames past the valid count read as zero
          if (idx < hdr_count[s] && idx < FPS) r.read_data = frame_mem[s*FPS + idx];
        end
      end
      default: begin
        if (ring_occupancy() == 0) r.status = STAT_EMPTY;
        else rd_ptr = (rd_ptr + 1) % PTR_SPAN;
      end
    endcase
    // header of the oldest committed slot, zero when none waits
    if (ring_occupancy() != 0) begin
      s = rd_ptr % SLOTS;
      r.start_offset  = hdr_offset[s];
      r.seq_no        = hdr_seq[s];
      r.frame_cnt     = hdr_count[s];
      r.final_partial = hdr_final[s];
    end
    r.occupancy      = 4'(ring_occupancy());
    r.partial_frames = 6'(fill);
    r.finalized      = finished;
    return r;
  endfunction

  // present one item, wait for its handshake, queue its result, then maybe idle
  task automatic issue(input op_t op, input logic [63:0] ofs, input logic [31:0] data,
                       input logic [5:0] idx, input logic pinned,
                       input status_t pin_status, input logic [31:0] pin_rdata);
    ring_report_t want;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, idx, data, ofs};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    want = apply_ring_op(op, ofs, data, idx);
    if (pinned) begin
      want.status    = pin_status;
      want.read_data = pin_rdata;
    end
    awaited_reports.push_back(want);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic run_directed();
    logic [63:0] ofs;
    logic [31:0] data;
    foreach (directed_plan[i]) begin
      for (int k = 0; k < directed_plan[i].reps; k++) begin
        ofs  = directed_plan[i].rel_offset ? next_offset + directed_plan[i].ofs :
                                             directed_plan[i].ofs;
        data = (directed_plan[i].reps > 1) ? $urandom : directed_plan[i].data;
        issue(directed_plan[i].op, ofs, data, directed_plan[i].idx,
              directed_plan[i].pinned, directed_plan[i].pin_status,
              directed_plan[i].pin_rdata);
      end
    end
  endtask

  // mostly in-order appends; the ring alternates between filling up and
  // draining so that full, empty and every occupancy in between are visited
  task automatic run_random(input int n_ops);
    int          roll;
    int          consume_pct;
    logic        draining;
    logic [63:0] noise_ofs;
    draining = 1'b0;
    for (int k = 0; k < n_ops; k++) begin
      // idling phases: sender light / receiver heavy, swapped, then none
      if (k == n_ops / 3) begin
        tx_idle_pct = 74;
        rx_idle_pct = 33;
      end else if (k == 2 * n_ops / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (ring_occupancy() == 0) draining = 1'b0;
      else if (ring_occupancy() == SLOTS && $urandom_range(0, 3) == 0) draining = 1'b1;
      consume_pct = draining ? 30 : 2;
      noise_ofs = {$urandom, $urandom};
      if (noise_ofs == next_offset) noise_ofs[0] = ~noise_ofs[0];
      roll = $urandom_range(0, 99);
      if (roll < 4)
        issue(OP_APPEND, noise_ofs, $urandom, 6'($urandom), 1'b0, STAT_OK, '0);
      else if (roll < 7)
        issue(OP_FINISH, noise_ofs, $urandom, 6'($urandom), 1'b0, STAT_OK, '0);
      else if (roll < 27)
        issue(OP_READ, {$urandom, $urandom}, $urandom, 6'($urandom_range(0, 63)),
              1'b0, STAT_OK, '0);
      else if (roll < 27 + consume_pct)
        issue(OP_CONSUME, {$urandom, $urandom}, $urandom, 6'($urandom), 1'b0, STAT_OK, '0);
      else
        issue(OP_APPEND, next_offset, $urandom, 6'($urandom), 1'b0, STAT_OK, '0);
    end
  endtask

  // drain, finish with either an empty or a partial slot, read the oldest slot,
  // if any, back across all indexes, then poke the finalized state
  task automatic close_stream();
    while (ring_occupancy() != 0)
      issue(OP_CONSUME, '0, '0, '0, 1'b0, STAT_OK, '0);
    if ($urandom_range(0, 1) == 1) begin
      while (fill != 0)
        issue(OP_APPEND, next_offset, $urandom, '0, 1'b0, STAT_OK, '0);
    end else if (fill == 0) begin
      repeat ($urandom_range(1, FPS - 1))
        issue(OP_APPEND, next_offset, $urandom, '0, 1'b0, STAT_OK, '0);
    end
    issue(OP_FINISH, next_offset, '0, '0, 1'b0, STAT_OK, '0);
    for (int i = 0; i < 64; i++)
      issue(OP_READ, '0, '0, 6'(i), 1'b0, STAT_OK, '0);
    issue(OP_FINISH, next_offset, '0, '0, 1'b0, STAT_OK, '0);
    issue(OP_APPEND, next_offset, $urandom, '0, 1'b0, STAT_OK, '0);
    issue(OP_APPEND, next_offset + 64'd3, $urandom, '0, 1'b0, STAT_OK, '0);
    issue(OP_CONSUME, '0, '0, '0, 1'b0, STAT_OK, '0);
    issue(OP_CONSUME, '0, '0, '0, 1'b0, STAT_OK, '0);
  endtask

  // receiver backpressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // result checker: every accepted item against the oldest prediction
  always @(posedge clk) begin
    ring_report_t want;
    ring_report_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status         = status_t'(out_tuser);
      got.read_data      = out_tdata[31:0];
      got.start_offset   = out_tdata[95:32];
      got.seq_no         = out_tdata[127:96];
      got.frame_cnt      = out_tdata[134:128];
      got.final_partial  = out_tdata[135];
      got.occupancy      = out_tdata[139:136];
      got.partial_frames = out_tdata[145:140];
      got.finalized      = out_tdata[146];
      if (awaited_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result item with nothing pending, status %0d", $time, got.status);
      end else begin
        want = awaited_reports.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: mismatch (expected/actual) status %0d/%0d rdata %h/%h",
                     $time, want.status, got.status, want.read_data, got.read_data);
            $display("  offset %h/%h seq %h/%h frames %0d/%0d last %0b/%0b",
                     want.start_offset, got.start_offset, want.seq_no, got.seq_no,
                     want.frame_cnt, got.frame_cnt,
                     want.final_partial, got.final_partial);
            $display("  occupancy %0d/%0d partial %0d/%0d finalized %0b/%0b",
                     want.occupancy, got.occupancy, want.partial_frames,
                     got.partial_frames, want.finalized, got.finalized);
          end
        end
      end
    end
  end

  // watchdog: too long without any handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random(RANDOM_OPS);
    close_stream();
    in_tvalid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    // then keep the clock running to catch stray result items
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### pcm_frame_slot_ring.f
rtl/pfsr_pkg.sv
rtl/pfsr_ctrl.sv
rtl/pfsr_dp.sv
rtl/pcm_frame_slot_ring.sv
rtl/pfsr_chk.sv
tb/sv/tb_pcm_frame_slot_ring.sv
